/* src/led_pkg.sv */
package led_pkg;

    localparam int HistoryLinesDefault = 8;
    localparam int LineBytesDefault = 64;

    localparam logic [7:0] PromptReset = 8'd93;
    localparam logic [7:0] WidthReset = 8'd80;
    localparam logic [7:0] CharSpace = 8'd32;
    localparam logic [7:0] CharDel = 8'd127;

    typedef enum logic [3:0] {
        OP_CHAR  = 4'd0,
        OP_RET   = 4'd1,
        OP_TAB   = 4'd2,
        OP_BKSP  = 4'd3,
        OP_DEL   = 4'd4,
        OP_RIGHT = 4'd5,
        OP_LEFT  = 4'd6,
        OP_UP    = 4'd7,
        OP_DOWN  = 4'd8,
        OP_HOME  = 4'd9,
        OP_END   = 4'd10,
        OP_PEEK  = 4'd11,
        OP_CLEAR = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_SUBMIT = 2'd1,
        KIND_PEEK   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_PROMPT   = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_SUBMIT   = 2'd2,
        CFG_COMPLETE = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INS_WR,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_PEEK_RD,
        ST_PEEK_OUT,
        ST_SCROLL,
        ST_STATUS,
        ST_CLR_PASS,
        ST_RET_DONE
    } state_t;

endpackage

/* src/line_editor_with_history.sv */
// Keystroke line editor with a ring of history lines.
// Input channel s_axis: one key per transaction. tdata carries operation,
// key_char, read_index and save_line. Output channel m_axis: zero or more
// character transactions (tuser = kind 1 submitted, 2 peeked) and then one
// status transaction with tlast high carrying cursor, scroll and length.
// Configuration writes use cfg_valid/cfg_ready with a register index.
// One key is handled at a time; s_axis_tready is high only while idle.
// Line editing goes through a line memory with one read and one write port,
// each byte moved by a read step and then a write step. After reset a clearing
// pass writes the reset prompt and zeros into every line slot before the first
// key is taken.
// A stalled receiver holds the current result; the block waits for it.
module line_editor_with_history #(
    parameter int HISTORY_LINES = led_pkg::HistoryLinesDefault,
    parameter int LINE_BYTES = led_pkg::LineBytesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // operation, key_char, read_index, save_line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_char, cursor_pos, scroll_pos,
                                        // text_length, complete_request
    output logic [1:0]  m_axis_tuser,   // result_kind
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import led_pkg::*;

    localparam int SW = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
    localparam int CW = $clog2(LINE_BYTES);
    localparam int AW = SW + CW;
    localparam int TOT = HISTORY_LINES * LINE_BYTES;
    localparam logic [6:0] MaxLen = 7'(LINE_BYTES - 2);

    state_t state_reg, state_next;

    logic [7:0] prompt_reg, width_reg;
    logic       submit_en_reg, complete_en_reg;

    logic [SW-1:0] edit_reg, edit_next, hist_reg, hist_next;
    logic [6:0]    cur_reg, cur_next;
    logic [6:0]    scroll_reg, scroll_next;
    logic [6:0]    len_arr_reg [HISTORY_LINES];
    logic [6:0]    len_wr_val;
    logic          len_wr;
    logic [SW-1:0] len_wr_slot;

    logic [3:0]    op_reg;
    logic [7:0]    key_reg;
    logic [5:0]    ridx_reg;
    logic          save_reg;
    logic          comp_reg, comp_next;

    // Shared address counter for shifts, copies, emits and peeks.
    logic [6:0]    k_reg, k_next;
    logic [6:0]    kend_reg, kend_next;
    logic [6:0]    k_adj;
    logic [AW:0]   clr_reg, clr_next;
    logic          dir_up_reg, dir_up_next;
    logic [SW-1:0] src_reg, src_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    logic [7:0]    out_char;
    logic [1:0]    kind_reg, kind_next;
    logic          last_reg, last_next;

    logic [6:0]    len_e;
    logic [SW-1:0] prev_slot, next_slot;

    led_line_ram #(.AddrWidth(AW)) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        slot_inc = (32'(s) == HISTORY_LINES - 1) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s);
        slot_dec = (s == '0) ? SW'(HISTORY_LINES - 1) : s - 1'b1;
    endfunction

    assign len_e = len_arr_reg[edit_reg];
    assign prev_slot = slot_dec(hist_reg);
    assign next_slot = slot_inc(hist_reg);
    assign k_adj = dir_up_reg ? k_reg + 7'd1 : k_reg - 7'd1;

    // The memory keeps reading the current column, so the byte holds under a stall.
    // Columns past the text read as zero on peek.
    assign out_char = (state_reg == ST_PEEK_OUT && k_reg > len_e) ? 8'd0 : rd_data;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_EMIT_OUT) || (state_reg == ST_PEEK_OUT)
                           || (state_reg == ST_STATUS);
    assign m_axis_tuser = kind_reg;
    assign m_axis_tlast = last_reg;
    assign m_axis_tdata = (state_reg == ST_STATUS)
        ? {5'd0, comp_reg, len_e[5:0], scroll_reg[5:0], cur_reg[5:0], 8'd0}
        : {24'd0, out_char};

    // Scroll arithmetic, evaluated in the dedicated step.
    logic signed [9:0] w2, ci, ln, s0, s1, s2, s3;
    always_comb begin
        w2 = (width_reg < 8'd3) ? 10'sd1 : $signed({2'b0, width_reg}) - 10'sd2;
        ci = $signed({3'b0, cur_reg}) - 10'sd1;
        ln = $signed({3'b0, len_e});
        s0 = $signed({3'b0, scroll_reg});
        s1 = (s0 > ci) ? ci : s0;
        s2 = (s1 + w2 - 10'sd1 < ci) ? ci - w2 + 10'sd1 : s1;
        s3 = (ln - s2 < w2) ? ((ln > w2) ? ln - w2 : 10'sd0) : s2;
        if (s3 < 0) s3 = 10'sd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR_PASS;
            prompt_reg <= PromptReset;
            width_reg <= WidthReset;
            submit_en_reg <= 1'b1;
            complete_en_reg <= 1'b0;
            edit_reg <= '0;
            hist_reg <= '0;
            cur_reg <= 7'd1;
            scroll_reg <= '0;
            clr_reg <= '0;
            for (int i = 0; i < HISTORY_LINES; i++) len_arr_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            edit_reg <= edit_next;
            hist_reg <= hist_next;
            cur_reg <= cur_next;
            scroll_reg <= scroll_next;
            clr_reg <= clr_next;
            if (len_wr) len_arr_reg[len_wr_slot] <= len_wr_val;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_PROMPT:   prompt_reg <= cfg_data;
                    CFG_WIDTH:    width_reg <= cfg_data;
                    CFG_SUBMIT:   submit_en_reg <= cfg_data[0];
                    CFG_COMPLETE: complete_en_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            op_reg <= s_axis_tdata[3:0];
            key_reg <= s_axis_tdata[11:4];
            ridx_reg <= s_axis_tdata[17:12];
            save_reg <= s_axis_tdata[18];
        end
        k_reg <= k_next;
        kend_reg <= kend_next;
        dir_up_reg <= dir_up_next;
        src_reg <= src_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
        comp_reg <= comp_next;
    end

    always_comb begin
        logic [SW-1:0] ns;
        state_next = state_reg;
        edit_next = edit_reg;
        hist_next = hist_reg;
        cur_next = cur_reg;
        scroll_next = scroll_reg;
        clr_next = clr_reg;
        k_next = k_reg;
        kend_next = kend_reg;
        dir_up_next = dir_up_reg;
        src_next = src_reg;
        kind_next = kind_reg;
        last_next = last_reg;
        comp_next = comp_reg;
        len_wr = 1'b0;
        len_wr_slot = edit_reg;
        len_wr_val = '0;
        wr_en = 1'b0;
        wr_addr = {edit_reg, k_reg[CW-1:0]};
        wr_data = rd_data;
        rd_addr = {edit_reg, k_reg[CW-1:0]};
        ns = slot_inc(edit_reg);

        unique case (state_reg)
            ST_CLR_PASS: begin
                wr_en = 1'b1;
                wr_addr = clr_reg[AW-1:0];
                wr_data = (clr_reg[CW-1:0] == '0) ? PromptReset : 8'd0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == TOT - 1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                comp_next = 1'b0;
                if (s_axis_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                state_next = ST_SCROLL;
                unique case (op_reg)
                    OP_CHAR: begin
                        if (key_reg >= CharSpace && key_reg != CharDel && len_e < MaxLen) begin
                            // Shift right from the end down to the cursor.
                            dir_up_next = 1'b0;
                            k_next = len_e + 7'd1;
                            kend_next = cur_reg;
                            state_next = (len_e + 7'd1 > cur_reg) ? ST_SHIFT_RD : ST_INS_WR;
                        end
                    end
                    OP_RET: begin
                        k_next = 7'd1;
                        kind_next = KIND_SUBMIT;
                        last_next = 1'b0;
                        state_next = (submit_en_reg && len_e != 7'd0) ? ST_EMIT_RD
                                                                      : ST_RET_DONE;
                    end
                    OP_TAB: comp_next = complete_en_reg;
                    OP_BKSP: begin
                        if (cur_reg > 7'd1) begin
                            dir_up_next = 1'b1;
                            k_next = cur_reg - 7'd1;
                            kend_next = len_e;
                            len_wr = 1'b1;
                            len_wr_val = len_e - 7'd1;
                            cur_next = cur_reg - 7'd1;
                            if (cur_reg - 7'd1 < len_e) state_next = ST_SHIFT_RD;
                        end
                    end
                    OP_DEL: begin
                        if (cur_reg <= len_e) begin
                            dir_up_next = 1'b1;
                            k_next = cur_reg;
                            kend_next = len_e;
                            len_wr = 1'b1;
                            len_wr_val = len_e - 7'd1;
                            if (cur_reg < len_e) state_next = ST_SHIFT_RD;
                        end
                    end
                    OP_RIGHT: if (cur_reg <= len_e) cur_next = cur_reg + 7'd1;
                    OP_LEFT: if (cur_reg > 7'd1) cur_next = cur_reg - 7'd1;
                    OP_UP: begin
                        if (prev_slot != edit_reg && len_arr_reg[prev_slot] != 0) begin
                            hist_next = prev_slot;
                            src_next = prev_slot;
                            k_next = '0;
                            kend_next = len_arr_reg[prev_slot];
                            len_wr = 1'b1;
                            len_wr_val = len_arr_reg[prev_slot];
                            cur_next = len_arr_reg[prev_slot] + 7'd1;
                            state_next = ST_COPY_RD;
                        end
                    end
                    OP_DOWN: begin
                        if (hist_reg != edit_reg) begin
                            hist_next = next_slot;
                            if (next_slot == edit_reg) begin
                                wr_en = 1'b1;
                                wr_addr = {edit_reg, {CW{1'b0}}};
                                wr_data = prompt_reg;
                                len_wr = 1'b1;
                                len_wr_val = '0;
                                cur_next = 7'd1;
                            end else begin
                                src_next = next_slot;
                                k_next = '0;
                                kend_next = len_arr_reg[next_slot];
                                len_wr = 1'b1;
                                len_wr_val = len_arr_reg[next_slot];
                                cur_next = len_arr_reg[next_slot] + 7'd1;
                                state_next = ST_COPY_RD;
                            end
                        end
                    end
                    OP_HOME: cur_next = 7'd1;
                    OP_END: cur_next = len_e + 7'd1;
                    OP_PEEK: begin
                        k_next = {1'b0, ridx_reg};
                        kind_next = KIND_PEEK;
                        last_next = 1'b0;
                        state_next = ST_PEEK_RD;
                    end
                    OP_CLEAR: begin
                        if (save_reg && len_e != 0) begin
                            edit_next = ns;
                            hist_next = ns;
                            len_wr_slot = ns;
                        end
                        wr_en = 1'b1;
                        wr_addr = {(save_reg && len_e != 0) ? ns : edit_reg, {CW{1'b0}}};
                        wr_data = prompt_reg;
                        len_wr = 1'b1;
                        len_wr_val = '0;
                        cur_next = 7'd1;
                        kind_next = KIND_STATUS;
                        last_next = 1'b1;
                        state_next = ST_STATUS;
                    end
                    default: ;
                endcase
                if (state_next == ST_SCROLL) begin
                    kind_next = KIND_STATUS;
                    last_next = 1'b1;
                end
            end
            ST_SHIFT_RD: begin
                rd_addr = {edit_reg, k_adj[CW-1:0]};
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                wr_en = 1'b1;
                wr_data = rd_data;
                if (dir_up_reg) begin
                    k_next = k_reg + 7'd1;
                    state_next = (k_reg + 7'd1 < kend_reg) ? ST_SHIFT_RD : ST_SCROLL;
                end else begin
                    k_next = k_reg - 7'd1;
                    state_next = (k_reg - 7'd1 > kend_reg) ? ST_SHIFT_RD : ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                wr_en = 1'b1;
                wr_addr = {edit_reg, cur_reg[CW-1:0]};
                wr_data = key_reg;
                len_wr = 1'b1;
                len_wr_val = len_e + 7'd1;
                cur_next = cur_reg + 7'd1;
                state_next = ST_SCROLL;
            end
            ST_COPY_RD: begin
                rd_addr = {src_reg, k_reg[CW-1:0]};
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                wr_en = 1'b1;
                wr_data = rd_data;
                k_next = k_reg + 7'd1;
                state_next = (k_reg < kend_reg) ? ST_COPY_RD : ST_SCROLL;
            end
            ST_EMIT_RD: state_next = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (m_axis_tready) begin
                    k_next = k_reg + 7'd1;
                    rd_addr = {edit_reg, k_reg[CW-1:0] + 1'b1};
                    state_next = (k_reg >= len_e) ? ST_RET_DONE : ST_EMIT_RD;
                end
            end
            ST_RET_DONE: begin
                // Return finishes like a saving clear: advance the ring if the line has text.
                if (len_e != 0) begin
                    edit_next = ns;
                    hist_next = ns;
                    len_wr_slot = ns;
                end
                wr_en = 1'b1;
                wr_addr = {(len_e != 0) ? ns : edit_reg, {CW{1'b0}}};
                wr_data = prompt_reg;
                len_wr = 1'b1;
                len_wr_val = '0;
                cur_next = 7'd1;
                kind_next = KIND_STATUS;
                last_next = 1'b1;
                state_next = ST_SCROLL;
            end
            ST_PEEK_RD: state_next = ST_PEEK_OUT;
            ST_PEEK_OUT: begin
                if (m_axis_tready) begin
                    kind_next = KIND_STATUS;
                    last_next = 1'b1;
                    state_next = ST_STATUS;
                end
            end
            ST_SCROLL: begin
                scroll_next = s3[6:0];
                kind_next = KIND_STATUS;
                last_next = 1'b1;
                state_next = ST_STATUS;
            end
            ST_STATUS: if (m_axis_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid |-> !s_axis_tready)) else $error("ready while output busy");
    a_cur_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE |-> (cur_reg >= 7'd1 && cur_reg <= len_e + 7'd1)))
        else $error("cursor out of range");
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE |-> len_e <= MaxLen)) else $error("length overflow");
`endif
endmodule

/* src/led_line_ram.sv */
module led_line_ram #(
    parameter int AddrWidth = 9
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AddrWidth-1:0] wr_addr,
    input  logic [7:0]           wr_data,
    input  logic [AddrWidth-1:0] rd_addr,
    output logic [7:0]           rd_data
);
    logic [7:0] mem [2**AddrWidth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* bench/line_editor_checker.sv */
module line_editor_checker
    import led_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          errors,
    output int          pending
);
    localparam int NLINES = 8;
    localparam int LSIZE = 64;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
        logic [5:0] cur;
        logic [5:0] scr;
        logic [5:0] len;
        logic       comp;
    } editor_result_t;

    editor_result_t awaited_results[$];

    logic [7:0] lines [NLINES][LSIZE];
    int         line_len [NLINES];
    int         edit_slot, hist_slot, cursor, scroll;
    logic [7:0] prompt, width;
    logic       submit_en, complete_en;

    assign pending = awaited_results.size();

    function automatic editor_result_t make_char(logic [1:0] kind, logic [7:0] ch);
        editor_result_t r;
        r = '0;
        r.kind = kind;
        r.ch = ch;
        return r;
    endfunction

    function automatic void clear_edit(bit save);
        if (save && line_len[edit_slot] != 0) begin
            edit_slot = (edit_slot + 1) % NLINES;
            hist_slot = edit_slot;
        end
        lines[edit_slot][0] = prompt;
        line_len[edit_slot] = 0;
        cursor = 1;
    endfunction

    function automatic void recall_history();
        int n;
        n = line_len[hist_slot];
        for (int k = 0; k <= n; k++) lines[edit_slot][k] = lines[hist_slot][k];
        line_len[edit_slot] = n;
        cursor = n + 1;
    endfunction

    function automatic void rescroll();
        int w2, i, len, s;
        w2 = (width < 3) ? 1 : int'(width) - 2;
        i = cursor - 1;
        len = line_len[edit_slot];
        s = scroll;
        if (s > i) s = i;
        if (s + w2 - 1 < i) s = i - w2 + 1;
        if (len - s < w2) s = (len > w2) ? len - w2 : 0;
        if (s < 0) s = 0;
        scroll = s;
    endfunction

    function automatic void predict_key(logic [23:0] key);
        logic [3:0] op;
        logic [7:0] ch;
        int         ridx, len, j;
        bit         save, redo;
        logic       comp;
        editor_result_t st;
        op = key[3:0];
        ch = key[11:4];
        ridx = key[17:12];
        save = key[18];
        len = line_len[edit_slot];
        comp = 1'b0;
        redo = 1;
        case (op)
            OP_CHAR: begin
                if (ch >= CharSpace && ch != CharDel && len + 2 < LSIZE) begin
                    for (int k = len + 1; k > cursor; k--)
                        lines[edit_slot][k] = lines[edit_slot][k-1];
                    lines[edit_slot][cursor] = ch;
                    line_len[edit_slot] = len + 1;
                    cursor++;
                end
            end
            OP_RET: begin
                if (submit_en)
                    for (int k = 1; k <= len; k++)
                        awaited_results.push_back(make_char(KIND_SUBMIT, lines[edit_slot][k]));
                clear_edit(1);
            end
            OP_TAB: comp = complete_en;
            OP_BKSP: begin
                if (cursor > 1) begin
                    for (int k = cursor - 1; k < len; k++)
                        lines[edit_slot][k] = lines[edit_slot][k+1];
                    line_len[edit_slot] = len - 1;
                    cursor--;
                end
            end
            OP_DEL: begin
                if (cursor <= len) begin
                    for (int k = cursor; k < len; k++)
                        lines[edit_slot][k] = lines[edit_slot][k+1];
                    line_len[edit_slot] = len - 1;
                end
            end
            OP_RIGHT: if (cursor <= len) cursor++;
            OP_LEFT: if (cursor > 1) cursor--;
            OP_UP: begin
                j = (hist_slot + NLINES - 1) % NLINES;
                if (j != edit_slot && line_len[j] != 0) begin
                    hist_slot = j;
                    recall_history();
                end
            end
            OP_DOWN: begin
                if (hist_slot != edit_slot) begin
                    hist_slot = (hist_slot + 1) % NLINES;
                    if (hist_slot == edit_slot) begin
                        lines[edit_slot][0] = prompt;
                        line_len[edit_slot] = 0;
                        cursor = 1;
                    end else begin
                        recall_history();
                    end
                end
            end
            OP_HOME: cursor = 1;
            OP_END: cursor = len + 1;
            OP_PEEK: begin
                awaited_results.push_back(make_char(KIND_PEEK,
                    (ridx <= len) ? lines[edit_slot][ridx] : 8'd0));
                redo = 0;
            end
            OP_CLEAR: begin
                clear_edit(save);
                redo = 0;
            end
            default: ;
        endcase
        if (redo) rescroll();
        st = '0;
        st.kind = KIND_STATUS;
        st.last = 1'b1;
        st.cur = cursor[5:0];
        st.scr = scroll[5:0];
        st.len = line_len[edit_slot][5:0];
        st.comp = comp;
        awaited_results.push_back(st);
    endfunction

    always @(posedge aclk) begin
        editor_result_t got, want;
        if (!aresetn) begin
            prompt <= PromptReset;
            width <= WidthReset;
            submit_en <= 1'b1;
            complete_en <= 1'b0;
            for (int s = 0; s < NLINES; s++) begin
                for (int k = 0; k < LSIZE; k++) lines[s][k] = 8'd0;
                lines[s][0] = PromptReset;
                line_len[s] = 0;
            end
            edit_slot = 0;
            hist_slot = 0;
            cursor = 1;
            scroll = 0;
            errors <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_PROMPT:   prompt <= cfg_data;
                    CFG_WIDTH:    width <= cfg_data;
                    CFG_SUBMIT:   submit_en <= cfg_data[0];
                    CFG_COMPLETE: complete_en <= cfg_data[0];
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser;
                got.ch = m_axis_tdata[7:0];
                got.cur = m_axis_tdata[13:8];
                got.scr = m_axis_tdata[19:14];
                got.len = m_axis_tdata[25:20];
                got.comp = m_axis_tdata[26];
                got.last = m_axis_tlast;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, got);
                    errors <= errors + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %h actual %h", $time, want, got);
                        errors <= errors + 1;
                    end
                end
            end
            // Prediction follows result checking so that this key's results queue behind.
            if (s_axis_tvalid && s_axis_tready) predict_key(s_axis_tdata);
        end
    end
endmodule

/* bench/tb_line_editor_with_history.sv */
module tb_line_editor_with_history;
    import led_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    int          errors, pending;
    bit          hold_off = 0;
    int          idle_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    line_editor_with_history u_top (.*);

    line_editor_checker u_chk (.*);

    // No key is accepted during the clearing pass after reset.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver stall pattern; a long hold-off is requested by the stimulus.
    always @(posedge aclk) begin
        int cnt;
        if (hold_off) begin
            m_axis_tready <= 1'b0;
            cnt = 0;
        end else begin
            cnt++;
            if ((cnt / 40) % 3 == 0) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic send_key(op_t op, logic [7:0] ch, logic [5:0] ridx, bit save);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, save, ridx, ch, op};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    task automatic random_key();
        int r;
        op_t op;
        r = $urandom_range(0, 99);
        if (r < 40) op = OP_CHAR;
        else if (r < 44) op = OP_RET;
        else if (r < 48) op = OP_UP;
        else if (r < 52) op = OP_DOWN;
        else op = op_t'($urandom_range(0, 15));
        send_key(op, (r < 35) ? 8'($urandom_range(32, 126)) : 8'($urandom),
                 6'($urandom), 1'($urandom));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: wide chars, edges, history, peeks, unused codes.
        write_reg(CFG_COMPLETE, 8'd1);
        send_key(OP_BKSP, 8'd0, 6'd0, 0);
        send_key(OP_LEFT, 8'd0, 6'd0, 0);
        send_key(OP_CHAR, 8'd31, 6'd0, 0);
        send_key(OP_CHAR, 8'd127, 6'd0, 0);
        send_key(OP_CHAR, 8'd255, 6'd0, 0);
        send_key(OP_CHAR, 8'd32, 6'd0, 0);
        send_key(OP_CHAR, 8'hAA, 6'd0, 0);
        send_key(OP_HOME, 8'd0, 6'd0, 0);
        send_key(OP_DEL, 8'd0, 6'd0, 0);
        send_key(OP_END, 8'd0, 6'd0, 0);
        send_key(OP_DEL, 8'd0, 6'd0, 0);
        send_key(OP_RIGHT, 8'd0, 6'd0, 0);
        send_key(OP_TAB, 8'd0, 6'd0, 0);
        send_key(OP_PEEK, 8'd0, 6'd0, 0);
        send_key(OP_PEEK, 8'd0, 6'd1, 0);
        send_key(OP_PEEK, 8'd0, 6'd63, 0);
        send_key(OP_RET, 8'd0, 6'd0, 0);
        send_key(OP_UP, 8'd0, 6'd0, 0);
        send_key(OP_UP, 8'd0, 6'd0, 0);
        send_key(OP_DOWN, 8'd0, 6'd0, 0);
        send_key(OP_CLEAR, 8'd0, 6'd0, 1);
        send_key(op_t'(4'd13), 8'd0, 6'd0, 0);
        send_key(op_t'(4'd15), 8'd0, 6'd0, 0);
        end_burst();
        drain();

        // Fill a line to capacity in a narrow display, then submit it.
        write_reg(CFG_WIDTH, 8'd0);
        write_reg(CFG_PROMPT, 8'd0);
        for (int i = 0; i < 64; i++) send_key(OP_CHAR, 8'($urandom_range(33, 255)), 6'd0, 0);
        end_burst();
        drain();
        // The sender keeps offering while the receiver holds off.
        hold_off = 1;
        fork
            begin
                repeat (600) @(posedge aclk);
                hold_off = 0;
            end
            begin
                send_key(OP_RET, 8'd0, 6'd0, 0);
                send_key(OP_PEEK, 8'd0, 6'd0, 0);
                send_key(OP_UP, 8'd0, 6'd0, 0);
                end_burst();
            end
        join
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_PROMPT, 8'hFF);
                    write_reg(CFG_WIDTH, 8'd3);
                    write_reg(CFG_SUBMIT, 8'd0);
                    write_reg(CFG_COMPLETE, 8'd0);
                end
                1: begin
                    write_reg(CFG_WIDTH, 8'd255);
                    write_reg(CFG_SUBMIT, 8'd1);
                end
                2: begin
                    write_reg(CFG_WIDTH, 8'd10);
                    write_reg(CFG_PROMPT, 8'h5A);
                    write_reg(CFG_COMPLETE, 8'd1);
                end
                default: write_reg(CFG_WIDTH, 8'($urandom_range(3, 40)));
            endcase
            for (int n = 0; n < 30;) begin
                int burst;
                burst = (n % 3 == 0) ? 25 : $urandom_range(1, 8);
                for (int b = 0; b < burst && n < 30; b++, n++) random_key();
                end_burst();
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
